[design/khm_pkg.sv]
// Package for the k-th largest selection unit (min-heap based).
// Holds the controller state type, the item and result structs and fixed field widths.
// Depends on nothing; khm_engine, the top level and the verification files import it.
`default_nettype none

package khm_pkg;

  // Fixed field widths
  localparam int unsigned DataW = 32;
  localparam int unsigned KSelW = 7;

  // Register indexes on the configuration port
  localparam logic RegKSelect = 1'b0;

  // Heap controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FIN
  } khm_state_e;

  // One input item
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } khm_item_t;

  // One result item
  typedef struct packed {
    logic signed [DataW-1:0] kth_value;
    logic                    too_few;
  } khm_result_t;

endpackage : khm_pkg

`default_nettype wire

[design/khm_ram.sv]
// Generic synchronous RAM: one write port, two read ports with registered read data.
// Contents are not reset. Depends on nothing.
`default_nettype none

module khm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [AW-1:0]    rd_addr_a_i,
  input  wire logic [AW-1:0]    rd_addr_b_i,
  output logic      [WIDTH-1:0] rd_data_a_o,
  output logic      [WIDTH-1:0] rd_data_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule : khm_ram

`default_nettype wire

[design/khm_engine.sv]
// Heap engine: keeps the min-heap of the k largest values in a RAM and runs
// sift-up on fill and sift-down on root replacement, with a read state and a compare state per heap level.
// Depends on khm_pkg and khm_ram.
`default_nettype none

module khm_engine
  import khm_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 64,
  parameter int unsigned CW = $clog2(HEAP_DEPTH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clear_i,
  input  wire logic [CW-1:0] k_eff_i,
  input  wire logic          item_valid_i,
  output logic               item_ready_o,
  input  wire khm_item_t     item_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output khm_result_t        res_o
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);

  khm_state_e state_q, state_d;
  logic [CW-1:0]           pos_q, pos_d;
  logic [CW-1:0]           fill_q, fill_d;
  logic signed [DataW-1:0] val_q, val_d;
  logic                    last_q, last_d;
  logic signed [DataW-1:0] root_q, root_d;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [DataW-1:0] wr_data;
  logic [AW-1:0]    rd_addr_a, rd_addr_b;
  logic [DataW-1:0] rd_data_a, rd_data_b;

  logic                    accept;
  logic [CW-1:0]           parent;
  logic [CW:0]             child_a, child_b;
  logic                    dn_leaf, use_b, up_stop, dn_stop, fill_open;
  logic signed [DataW-1:0] child_val;
  logic [CW-1:0]           child_pos;

  khm_ram #(
    .WIDTH (DataW),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  // Heap index arithmetic and compares
  assign accept    = item_valid_i && item_ready_o;
  assign fill_open = fill_q < k_eff_i;
  assign parent    = (pos_q - CW'(1)) >> 1;
  assign child_a   = {pos_q, 1'b1};
  assign child_b   = child_a + (CW+1)'(1);
  assign dn_leaf   = child_a >= {1'b0, k_eff_i};
  assign use_b     = (child_b < {1'b0, k_eff_i}) && ($signed(rd_data_b) < $signed(rd_data_a));
  assign child_val = use_b ? $signed(rd_data_b) : $signed(rd_data_a);
  assign child_pos = use_b ? child_b[CW-1:0] : child_a[CW-1:0];
  assign up_stop   = $signed(rd_data_a) <= val_q;
  assign dn_stop   = val_q <= child_val;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (fill_open) begin
            state_d = ST_UP_RD;
          end else if (item_i.value > root_q) begin
            state_d = ST_DN_RD;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_UP_RD:  state_d = (pos_q == '0) ? ST_FIN : ST_UP_CMP;
      ST_UP_CMP: state_d = up_stop ? ST_FIN : ST_UP_RD;
      ST_DN_RD:  state_d = dn_leaf ? ST_FIN : ST_DN_CMP;
      ST_DN_CMP: state_d = dn_stop ? ST_FIN : ST_DN_RD;
      ST_FIN: begin
        if (!last_q || res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    pos_d        = pos_q;
    fill_d       = fill_q;
    val_d        = val_q;
    last_d       = last_q;
    root_d       = root_q;
    wr_en        = 1'b0;
    wr_addr      = pos_q[AW-1:0];
    wr_data      = val_q;
    rd_addr_a    = parent[AW-1:0];
    rd_addr_b    = child_b[AW-1:0];
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (accept) begin
          val_d  = item_i.value;
          last_d = item_i.last;
          if (fill_open) begin
            pos_d  = fill_q;
            fill_d = fill_q + CW'(1);
          end else begin
            pos_d = '0;
          end
        end
      end
      ST_UP_RD: begin
        // Place the value at the root, or fetch the parent
        if (pos_q == '0) begin
          wr_en = 1'b1;
        end
      end
      ST_UP_CMP: begin
        // Stop below a smaller or equal parent, else move the parent down
        wr_en = 1'b1;
        if (!up_stop) begin
          wr_data = rd_data_a;
          pos_d   = parent;
        end
      end
      ST_DN_RD: begin
        // Place the value at a leaf, or fetch both children
        rd_addr_a = child_a[AW-1:0];
        if (dn_leaf) begin
          wr_en = 1'b1;
        end
      end
      ST_DN_CMP: begin
        // Stop when no child is smaller, else move the smaller child up
        wr_en = 1'b1;
        if (!dn_stop) begin
          wr_data = child_val;
          pos_d   = child_pos;
        end
      end
      ST_FIN: begin
        res_valid_o = last_q;
        if (last_q && res_ready_i) begin
          fill_d = '0;
        end
      end
      default: ;
    endcase
    // Mirror the root entry
    if (wr_en && (wr_addr == '0)) begin
      root_d = wr_data;
    end
    // Register write restarts the set
    if (clear_i) begin
      fill_d = '0;
    end
  end

  assign res_o.kth_value = root_q;
  assign res_o.too_few   = fill_open;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    val_q  <= val_d;
    last_q <= last_d;
    root_q <= root_d;
  end

endmodule : khm_engine

`default_nettype wire

[design/kth_largest_min_heap_unit.sv]
// K-th largest selection unit: top level with APB register, stream ports and result register.
// Depends on khm_pkg and khm_engine. Reset: k_select = 1, heap empty, RAM not cleared.
// A value at or below the full heap's root is dropped. A fill insert or a root replacement
// walks the heap level by level, with one RAM read state and one compare state per level,
// over at most floor(log2(k)) levels, until a compare ends the walk or it reaches the root
// or a leaf; the result goes into the result register, and a stalled result holds.
`default_nettype none

module kth_largest_min_heap_unit
  import khm_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Input stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [DataW-1:0] s_axis_tdata,   // [31:0] value
  input  wire logic             s_axis_tlast,
  // Result stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [DataW-1:0] m_axis_tdata,   // [31:0] kth_value
  output logic                  m_axis_tuser,   // [0] too_few
  // Configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

  logic [KSelW-1:0] k_select_q;
  logic [CW-1:0]    k_eff;
  logic             cfg_wr;
  logic             out_valid_q;
  khm_result_t      out_q;
  khm_result_t      res;
  khm_item_t        item;
  logic             res_valid, res_ready;

  // Register write decode
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegKSelect);
  assign prdata = (paddr[2] == RegKSelect) ? {{(32-KSelW){1'b0}}, k_select_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_select_q <= KSelW'(1);
    end else if (cfg_wr) begin
      k_select_q <= pwdata[KSelW-1:0];
    end
  end

  // Clamp k into 1..HEAP_DEPTH
  always_comb begin
    if (k_select_q == '0) begin
      k_eff = CW'(1);
    end else if (32'(k_select_q) > 32'(HEAP_DEPTH)) begin
      k_eff = CW'(HEAP_DEPTH);
    end else begin
      k_eff = CW'(k_select_q);
    end
  end

  assign item.value = s_axis_tdata;
  assign item.last  = s_axis_tlast;

  khm_engine #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (cfg_wr),
    .k_eff_i      (k_eff),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // Result register: load when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.kth_value;
  assign m_axis_tuser  = out_q.too_few;

  // An accepted item keeps the engine busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("engine took a second item while still working");

  // Clamped rank stays inside the heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_eff != '0) && (32'(k_eff) <= 32'(HEAP_DEPTH)))
    else $error("effective rank out of range");

  // With k of one every set fills the heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (k_eff == CW'(1)) |-> !m_axis_tuser)
    else $error("too_few flagged with rank one");

endmodule : kth_largest_min_heap_unit

`default_nettype wire

[verif/khm_checker.sv]
// Checker for the k-th largest selection unit: watches the stream and APB channels,
// keeps its own min-heap of the k largest values and compares every result transaction.
// Depends on khm_pkg; instantiated beside the block by tb_kth_largest_min_heap_unit.

module khm_checker
  import khm_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,   // [31:0] value
  input  logic             s_axis_tlast,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [DataW-1:0] m_axis_tdata,   // [31:0] kth_value
  input  logic             m_axis_tuser,   // [0] too_few
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic [31:0]      prdata,
  input  logic             pready,
  output int               err_cnt_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KSelAddr = {RegKSelect, 2'b00};

  // Shadow heap, fill level and rank register
  logic signed [DataW-1:0] heap_q [HEAP_DEPTH];
  int unsigned             fill_cnt = 0;
  logic [KSelW-1:0]        k_reg = KSelW'(1);
  khm_result_t             kth_q [$];

  // Clamp the programmed rank into 1..HEAP_DEPTH
  function automatic int unsigned rank_limit(input logic [KSelW-1:0] k);
    if (k == '0) return 1;
    if (k > HEAP_DEPTH) return HEAP_DEPTH;
    return k;
  endfunction

  // Fold one value into the heap; on the closing value queue the k-th largest
  task automatic absorb_value(input logic signed [DataW-1:0] v, input logic closing);
    int unsigned kk;
    int unsigned pos;
    int unsigned parent;
    int unsigned child;
    khm_result_t res;
    kk = rank_limit(k_reg);
    if (fill_cnt > kk) fill_cnt = kk;
    if (fill_cnt < kk) begin
      // append at the tail and climb while the parent is larger
      pos = fill_cnt;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (heap_q[parent] <= v) break;
        heap_q[pos] = heap_q[parent];
        pos = parent;
      end
      heap_q[pos] = v;
      fill_cnt++;
    end else if (v > heap_q[0]) begin
      // replace the root and sink it below the smaller child
      pos = 0;
      while (pos * 2 + 1 < kk) begin
        child = pos * 2 + 1;
        if (child + 1 < kk && heap_q[child + 1] < heap_q[child]) child++;
        if (v <= heap_q[child]) break;
        heap_q[pos] = heap_q[child];
        pos = child;
      end
      heap_q[pos] = v;
    end
    if (closing) begin
      res.kth_value = heap_q[0];
      res.too_few   = (fill_cnt < kk);
      kth_q.push_back(res);
      fill_cnt = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    khm_result_t got;
    khm_result_t want;
    if (!rst_ni) begin
      k_reg = KSelW'(1);
      fill_cnt = 0;
      kth_q.delete();
      pending_o = 0;
    end else begin
      // Compare a result transaction with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got.kth_value = m_axis_tdata;
        got.too_few   = m_axis_tuser;
        if (kth_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: unexpected result: expected none, actual kth_value %0d too_few %0b",
                   $time, got.kth_value, got.too_few);
        end else begin
          want = kth_q.pop_front();
          if (got.kth_value !== want.kth_value) begin
            err_cnt_o++;
            $display("%0t: kth_value mismatch: expected %0d, actual %0d",
                     $time, want.kth_value, got.kth_value);
          end
          if (got.too_few !== want.too_few) begin
            err_cnt_o++;
            $display("%0t: too_few mismatch: expected %0b, actual %0b",
                     $time, want.too_few, got.too_few);
          end
        end
      end

      // Advance the shadow heap on each input transaction
      if (s_axis_tvalid && s_axis_tready) absorb_value(s_axis_tdata, s_axis_tlast);

      // Track register writes; a rank write restarts the current set
      if (psel && penable && pready && pwrite && paddr == KSelAddr) begin
        k_reg = pwdata[KSelW-1:0];
        fill_cnt = 0;
      end

      // Check register read-back
      if (psel && penable && pready && !pwrite && paddr == KSelAddr) begin
        if (prdata !== {{(32-KSelW){1'b0}}, k_reg}) begin
          err_cnt_o++;
          $display("%0t: k_select read mismatch: expected %0d, actual %0d",
                   $time, k_reg, prdata);
        end
      end

      pending_o = kth_q.size();
    end
  end

endmodule : khm_checker

[verif/tb_kth_largest_min_heap_unit.sv]
// Testbench top for the k-th largest selection unit: clock, reset, stream and APB stimulus.
// Depends on khm_pkg, kth_largest_min_heap_unit and khm_checker, which does all checking.

module tb_kth_largest_min_heap_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import khm_pkg::*;

  localparam int unsigned HeapDepth  = 64;
  localparam int unsigned DrainPad   = 40;
  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned PhaseItems = 45;
  localparam logic [2:0]  KSelAddr   = {RegKSelect, 2'b00};
  localparam logic [2:0]  SpareAddr  = 3'd4;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;    // [31:0] value
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;         // [31:0] kth_value
  logic             m_axis_tuser;         // [0] too_few
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  int               err_cnt;
  int               pending;
  int unsigned      cycle_cnt = 0;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_stall_pct = 0;
  int unsigned      tx_mix [4] = '{0, 50, 0, 31};
  int unsigned      rx_mix [4] = '{0, 0, 50, 31};
  logic [KSelW-1:0] k_sweep [8] = '{7'd1, 7'd0, 7'd2, 7'd5, 7'd13, 7'd33, 7'd64, 7'd127};

  kth_largest_min_heap_unit #(.HEAP_DEPTH(HeapDepth)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  khm_checker #(.HEAP_DEPTH(HeapDepth)) u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Stall the result channel at the current rate
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Abort a hung run
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("tb_kth_largest_min_heap_unit: errors");
    $finish;
  end

  // Present one value and hold it until the block takes it
  task automatic send_item(input logic [DataW-1:0] v, input logic closing);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= closing;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid, wait until every expected result is in, then let the engine settle
  task automatic drain(input int unsigned pad);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (pad) @(posedge clk_i);
  endtask

  // One APB transaction: setup cycle, access cycle, then the bus goes idle
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Program the rank with junk in the unused bits, then read it back
  task automatic write_k(input logic [KSelW-1:0] k);
    logic [31:0] word;
    word = $urandom();
    word[KSelW-1:0] = k;
    drain(DrainPad);
    apb_access(1'b1, KSelAddr, word);
    apb_access(1'b0, KSelAddr, '0);
  endtask

  // Mix of duplicates near zero, full-range values and the signed extremes
  function automatic logic [DataW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return DataW'($urandom_range(0, 40)) - DataW'(20);
    if (sel < 9) return DataW'($urandom());
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic send_set(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(pick_value(), i == len - 1);
  endtask

  initial begin
    int unsigned kk;
    int unsigned len;
    int unsigned n;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rank one out of reset: single-value sets at both extremes
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 1'b1);

    // Rank four: a short set reports its minimum with too_few
    write_k(7'd4);
    send_item(32'd5, 1'b0);
    send_item(32'hFFFF_FFF9, 1'b1);

    // Fill, replace the root, drop smaller and equal values
    send_item(32'd10, 1'b0);
    send_item(32'd20, 1'b0);
    send_item(32'd30, 1'b0);
    send_item(32'd40, 1'b0);
    send_item(32'd50, 1'b0);
    send_item(32'd5, 1'b0);
    send_item(32'd20, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b1);

    // Abandon a set half way: a rank write restarts it; rank zero acts as one
    send_item(32'h5555_5555, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    write_k(7'd0);
    send_item(32'd3, 1'b0);
    send_item(32'hFFFF_FFFD, 1'b1);

    // Rank above capacity clamps to the heap depth
    write_k(7'd127);
    send_item(32'd1, 1'b0);
    send_item(32'd2, 1'b1);

    // A write to an unmapped address changes nothing
    drain(DrainPad);
    apb_access(1'b1, SpareAddr, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 1'b1);

    // Random sets across every idle mix and rank setting
    for (int m = 0; m < 4; m++) begin
      tx_idle_pct  = tx_mix[m];
      rx_stall_pct = rx_mix[m];
      for (int c = 0; c < 8; c++) begin
        write_k(k_sweep[c]);
        kk = (k_sweep[c] == '0) ? 1 : (k_sweep[c] > HeapDepth) ? HeapDepth : k_sweep[c];
        n = 0;
        while (n < PhaseItems) begin
          if ($urandom_range(0, 4) == 0) len = $urandom_range(1, kk);
          else len = kk + $urandom_range(0, kk / 2 + 8);
          send_set(len);
          n += len;
          // hold off now and then until the results catch up
          if ($urandom_range(0, 9) == 0) drain(0);
        end
      end
    end

    drain(DrainPad);
    if (err_cnt == 0 && pending == 0) begin
      $display("tb_kth_largest_min_heap_unit: clean");
    end else begin
      $display("tb_kth_largest_min_heap_unit: errors");
    end
    $finish;
  end

endmodule : tb_kth_largest_min_heap_unit
